// File: design/bdrp_pkg.sv
package bdrp_pkg;

  // result event codes
  typedef enum logic [2:0] {
    EV_EXPORT  = 3'd0,
    EV_UNSUP   = 3'd1,
    EV_READ    = 3'd2,
    EV_WDATA   = 3'd3,
    EV_WDONE   = 3'd4,
    EV_DISC    = 3'd5,
    EV_UNKNOWN = 3'd6
  } event_t;

  // one result item
  typedef struct packed {
    event_t      event_res;
    logic [63:0] handle;
    logic [63:0] offset;
    logic [31:0] length;
    logic [31:0] option_code;
    logic [7:0]  data_byte;
    logic [15:0] command_type;
  } result_t;

  // option and request type codes
  localparam logic [31:0] EXPORT_OPTION = 32'd1;
  localparam logic [15:0] CMD_READ      = 16'd0;
  localparam logic [15:0] CMD_WRITE     = 16'd1;
  localparam logic [15:0] CMD_DISC      = 16'd2;

  // byte positions inside the headers
  localparam logic [4:0] FLAGS_LAST     = 5'd3;
  localparam logic [4:0] OPT_CODE_FIRST = 5'd8;
  localparam logic [4:0] OPT_CODE_LAST  = 5'd11;
  localparam logic [4:0] OPT_LEN_FIRST  = 5'd12;
  localparam logic [4:0] OPT_HDR_LAST   = 5'd15;
  localparam logic [4:0] REQ_TYPE_FIRST = 5'd6;
  localparam logic [4:0] REQ_TYPE_LAST  = 5'd7;
  localparam logic [4:0] REQ_HND_FIRST  = 5'd8;
  localparam logic [4:0] REQ_HND_LAST   = 5'd15;
  localparam logic [4:0] REQ_OFF_FIRST  = 5'd16;
  localparam logic [4:0] REQ_OFF_LAST   = 5'd23;
  localparam logic [4:0] REQ_LEN_FIRST  = 5'd24;
  localparam logic [4:0] REQ_HDR_LAST   = 5'd27;

endpackage

// File: design/bdrp_if.sv
// received byte channel
interface bdrp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// result event channel
interface bdrp_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [63:0] handle;
  logic [63:0] offset;
  logic [31:0] length;
  logic [31:0] option_code;
  logic [7:0]  data_byte;
  logic [15:0] command_type;

  modport source (output valid, output event_res, output handle, output offset,
                  output length, output option_code, output data_byte,
                  output command_type, input ready);
  modport sink (input valid, input event_res, input handle, input offset,
                input length, input option_code, input data_byte,
                input command_type, output ready);
endinterface

// File: design/block_device_request_parser.sv
// A result is registered: the byte that causes it passes through the input register, then
// the result register.
// Throughput: one byte per cycle, set by the combinational parse step between the registers;
// a held result stalls the parse step, and so the input, until it is transferred.
// Reset (rst, synchronous, active high): flags phase, all parse state and export size
// cleared, both pipeline registers empty.
module block_device_request_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [63:0]        cfg_wr_data,
  bdrp_byte_if.sink          byte_ch,
  bdrp_event_if.source       event_ch
);

  typedef enum logic [2:0] {
    PH_FLAGS   = 3'd0,
    PH_OPTHDR  = 3'd1,
    PH_OPTSKIP = 3'd2,
    PH_REQHDR  = 3'd3,
    PH_WDATA   = 3'd4,
    PH_CLOSED  = 3'd5
  } phase_t;

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              step;

  logic [63:0]       export_size;

  phase_t            phase, phase_next;
  logic [4:0]        byte_index, byte_index_next;
  logic [31:0]       option_word, option_word_next;
  logic [15:0]       request_type, request_type_next;
  logic [63:0]       request_handle, request_handle_next;
  logic [63:0]       request_offset, request_offset_next;
  logic [31:0]       remaining_bytes, remaining_bytes_next;

  logic              res_emit;
  bdrp_pkg::result_t res_next;
  logic              opt_done;
  logic              hdr_done;
  logic [31:0]       left;

  logic              o_valid;
  bdrp_pkg::result_t o_res;

  // parse step fires when the result register can take a result
  assign step          = s1_valid && (!o_valid || event_ch.ready);
  assign byte_ch.ready = !s1_valid || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ch.ready) begin
      s1_valid <= byte_ch.valid;
    end
    if (byte_ch.ready && byte_ch.valid) begin
      s1_byte <= byte_ch.in_byte;
    end
  end

  // export size register
  always_ff @(posedge clk) begin
    if (rst) begin
      export_size <= '0;
    end else if (cfg_wr_en) begin
      export_size <= cfg_wr_data;
    end
  end

  // parse step
  always_comb begin
    phase_next           = phase;
    byte_index_next      = byte_index;
    option_word_next     = option_word;
    request_type_next    = request_type;
    request_handle_next  = request_handle;
    request_offset_next  = request_offset;
    remaining_bytes_next = remaining_bytes;
    res_emit             = 1'b0;
    res_next             = '0;
    opt_done             = 1'b0;
    hdr_done             = 1'b0;
    left                 = (remaining_bytes != 32'd0) ? remaining_bytes - 32'd1 : 32'd0;

    case (phase)
      PH_FLAGS: begin
        if (byte_index >= bdrp_pkg::FLAGS_LAST) begin
          byte_index_next = '0;
          phase_next      = PH_OPTHDR;
        end else begin
          byte_index_next = byte_index + 5'd1;
        end
      end
      PH_OPTHDR: begin
        if (byte_index >= bdrp_pkg::OPT_CODE_FIRST && byte_index <= bdrp_pkg::OPT_CODE_LAST) begin
          option_word_next = {option_word[23:0], s1_byte};
        end else if (byte_index >= bdrp_pkg::OPT_LEN_FIRST
                     && byte_index <= bdrp_pkg::OPT_HDR_LAST) begin
          remaining_bytes_next = {remaining_bytes[23:0], s1_byte};
        end
        if (byte_index >= bdrp_pkg::OPT_HDR_LAST) begin
          byte_index_next = '0;
          if (remaining_bytes_next == 32'd0) begin
            opt_done = 1'b1;
          end else begin
            phase_next = PH_OPTSKIP;
          end
        end else begin
          byte_index_next = byte_index + 5'd1;
        end
      end
      PH_OPTSKIP: begin
        remaining_bytes_next = left;
        if (left == 32'd0) begin
          opt_done = 1'b1;
        end
      end
      PH_REQHDR: begin
        if (byte_index >= bdrp_pkg::REQ_TYPE_FIRST && byte_index <= bdrp_pkg::REQ_TYPE_LAST) begin
          request_type_next = {request_type[7:0], s1_byte};
        end else if (byte_index >= bdrp_pkg::REQ_HND_FIRST
                     && byte_index <= bdrp_pkg::REQ_HND_LAST) begin
          request_handle_next = {request_handle[55:0], s1_byte};
        end else if (byte_index >= bdrp_pkg::REQ_OFF_FIRST
                     && byte_index <= bdrp_pkg::REQ_OFF_LAST) begin
          request_offset_next = {request_offset[55:0], s1_byte};
        end else if (byte_index >= bdrp_pkg::REQ_LEN_FIRST
                     && byte_index <= bdrp_pkg::REQ_HDR_LAST) begin
          remaining_bytes_next = {remaining_bytes[23:0], s1_byte};
        end
        if (byte_index >= bdrp_pkg::REQ_HDR_LAST) begin
          hdr_done = 1'b1;
        end else begin
          byte_index_next = byte_index + 5'd1;
        end
      end
      PH_WDATA: begin
        remaining_bytes_next  = left;
        request_offset_next   = request_offset + 64'd1;
        res_emit              = 1'b1;
        res_next.handle       = request_handle;
        res_next.offset       = request_offset;
        res_next.length       = left;
        res_next.data_byte    = s1_byte;
        res_next.command_type = request_type;
        if (left == 32'd0) begin
          phase_next         = PH_REQHDR;
          byte_index_next    = '0;
          res_next.event_res = bdrp_pkg::EV_WDONE;
        end else begin
          res_next.event_res = bdrp_pkg::EV_WDATA;
        end
      end
      default: begin
        // closed link and unused codes: byte is dropped
      end
    endcase

    // end of an option: export reply or refusal
    if (opt_done) begin
      byte_index_next      = '0;
      res_emit             = 1'b1;
      res_next.option_code = option_word_next;
      if (option_word_next == bdrp_pkg::EXPORT_OPTION) begin
        phase_next         = PH_REQHDR;
        res_next.event_res = bdrp_pkg::EV_EXPORT;
        res_next.offset    = export_size;
      end else begin
        phase_next         = PH_OPTHDR;
        res_next.event_res = bdrp_pkg::EV_UNSUP;
      end
    end

    // end of a request header
    if (hdr_done) begin
      byte_index_next = '0;
      if (request_type_next == bdrp_pkg::CMD_WRITE) begin
        if (remaining_bytes_next == 32'd0) begin
          res_emit              = 1'b1;
          res_next.event_res    = bdrp_pkg::EV_WDONE;
          res_next.handle       = request_handle_next;
          res_next.offset       = request_offset_next;
          res_next.command_type = request_type_next;
        end else begin
          phase_next = PH_WDATA;
        end
      end else begin
        res_emit              = 1'b1;
        res_next.handle       = request_handle_next;
        res_next.offset       = request_offset_next;
        res_next.length       = remaining_bytes_next;
        res_next.command_type = request_type_next;
        if (request_type_next == bdrp_pkg::CMD_READ) begin
          res_next.event_res = bdrp_pkg::EV_READ;
        end else if (request_type_next == bdrp_pkg::CMD_DISC) begin
          res_next.event_res = bdrp_pkg::EV_DISC;
          phase_next         = PH_CLOSED;
        end else begin
          res_next.event_res = bdrp_pkg::EV_UNKNOWN;
        end
      end
    end
  end

  // parse state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_FLAGS;
      byte_index      <= '0;
      option_word     <= '0;
      request_type    <= '0;
      request_handle  <= '0;
      request_offset  <= '0;
      remaining_bytes <= '0;
      o_valid         <= 1'b0;
    end else begin
      if (step) begin
        phase           <= phase_next;
        byte_index      <= byte_index_next;
        option_word     <= option_word_next;
        request_type    <= request_type_next;
        request_handle  <= request_handle_next;
        request_offset  <= request_offset_next;
        remaining_bytes <= remaining_bytes_next;
      end
      if (step && res_emit) begin
        o_valid <= 1'b1;
      end else if (event_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
    if (step && res_emit) begin
      o_res <= res_next;
    end
  end

  assign event_ch.valid        = o_valid;
  assign event_ch.event_res    = o_res.event_res;
  assign event_ch.handle       = o_res.handle;
  assign event_ch.offset       = o_res.offset;
  assign event_ch.length       = o_res.length;
  assign event_ch.option_code  = o_res.option_code;
  assign event_ch.data_byte    = o_res.data_byte;
  assign event_ch.command_type = o_res.command_type;

  // a closed link never produces a result
  a_closed_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CLOSED) |-> !res_emit)
    else $error("result produced on closed link");

  // write data always has bytes still to come
  a_wdata_len: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_res.event_res == bdrp_pkg::EV_WDATA) |-> (o_res.length != 32'd0))
    else $error("write data event with zero remaining length");

  // header position stays inside the request header
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    byte_index <= bdrp_pkg::REQ_HDR_LAST)
    else $error("byte index out of range");

  // a held result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !event_ch.ready) |=> (o_res == $past(o_res)))
    else $error("pending result overwritten");

endmodule
